### sv/cbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_pkg
// Shared constants, codes and control structs of the collision bitmap probe.
// ----------------------------------------------------------------------------
package cbp_pkg;

  // Map store dimensions
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int MAP_BITS   = MAX_WIDTH * MAX_HEIGHT;
  localparam int MAP_AW     = $clog2(MAP_BITS);
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  // probe coordinates reach box position + box size + 1 = 1535
  localparam int COORD_W    = (DIM_W > 11) ? DIM_W : 11;

  // Port field widths
  localparam int CMD_W      = 2;
  localparam int INDEX_W    = 18;
  localparam int PIXEL_W    = 32;
  localparam int POS_W      = 9;
  localparam int SIZE_W     = 10;
  localparam int DIMREG_W   = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_GROUND = 2'd1,
    CMD_WALL   = 2'd2
  } cbp_command_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1,
    REG_COLOR_KEY  = 2'd2
  } cbp_reg_t;

  // controller -> datapath
  typedef struct packed {
    logic load_we;
    logic capture;
    logic setup;
    logic step;
    logic push;
  } cbp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic count_one;
  } cbp_status_t;

  // map dimension register saturated to the store size
  function automatic logic [COORD_W-1:0] sat_dim(input logic [DIMREG_W-1:0] v,
                                                 input int max_dim);
    logic [COORD_W-1:0] lim;
    lim = COORD_W'(max_dim);
    if (COORD_W'(v) > lim) begin
      return lim;
    end
    return COORD_W'(v);
  endfunction

endpackage

### sv/cbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cbp_ram #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/cbp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_ctrl
// Sequencer for loads and edge probes, plus the result handshake.
// ----------------------------------------------------------------------------
module cbp_ctrl
  import cbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] command,
  output logic             out_valid,
  input  logic             out_stall,
  output cbp_cmd_t         cmd,
  input  cbp_status_t      status
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_LOAD) begin
            cmd.load_we = 1'b1;
          end else if (command == CMD_GROUND || command == CMD_WALL) begin
            cmd.capture = 1'b1;
            state_next  = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = status.count_zero ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.count_one) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data lands in the accumulator this cycle
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/cbp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_datapath
// Config registers, solid map store, probe walker and result register.
// ----------------------------------------------------------------------------
module cbp_datapath
  import cbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cbp_cmd_t              cmd,
  output cbp_status_t           status,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CMD_W-1:0]      command,
  input  logic [INDEX_W-1:0]    pixel_index,
  input  logic [PIXEL_W-1:0]    pixel_value,
  input  logic [POS_W-1:0]      box_x,
  input  logic [POS_W-1:0]      box_y,
  input  logic [SIZE_W-1:0]     box_w,
  input  logic [SIZE_W-1:0]     box_h,
  input  logic                  facing_left,
  output logic                  contact,
  output logic                  outside_map
);

  logic [COORD_W-1:0]   eff_w;
  logic [COORD_W-1:0]   eff_h;
  logic [PIXEL_W-1:0]   color_key;

  logic [COORD_W-1:0]   col;
  logic [COORD_W-1:0]   row;
  logic                 col_neg;
  logic                 walk_cols;
  logic [SIZE_W-1:0]    count;
  logic [MAP_AW-1:0]    addr;
  logic                 hit;
  logic                 outside;
  logic                 rd_pend;

  logic [2*COORD_W-1:0] prod;
  logic                 in_map;
  logic                 map_we;
  logic                 rd_en;
  logic [0:0]           rd_data;
  logic [0:0]           wr_bit;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w     <= sat_dim(DIMREG_W'(512), MAX_WIDTH);
      eff_h     <= sat_dim(DIMREG_W'(512), MAX_HEIGHT);
      color_key <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  eff_w     <= sat_dim(cfg_data[DIMREG_W-1:0], MAX_WIDTH);
        REG_MAP_HEIGHT: eff_h     <= sat_dim(cfg_data[DIMREG_W-1:0], MAX_HEIGHT);
        REG_COLOR_KEY:  color_key <= cfg_data;
        default: ;
      endcase
    end
  end

  // map store
  assign map_we    = cmd.load_we && (32'(pixel_index) < 32'(MAP_BITS));
  assign wr_bit[0] = (pixel_value != color_key);
  assign in_map    = !col_neg && (col < eff_w) && (row < eff_h);
  assign rd_en     = cmd.step && in_map;

  cbp_ram #(
    .DATA_W (1),
    .DEPTH  (MAP_BITS)
  ) u_map (
    .clk     (clk),
    .we      (map_we),
    .wr_addr (MAP_AW'(pixel_index)),
    .wr_data (wr_bit),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  assign prod              = row * eff_w;
  assign status.count_zero = (count == '0);
  assign status.count_one  = (count == SIZE_W'(1));

  // probe walker
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      walk_cols <= (command == CMD_GROUND);
      hit       <= 1'b0;
      outside   <= 1'b0;
      if (command == CMD_GROUND) begin
        col     <= COORD_W'(box_x);
        row     <= COORD_W'(box_y) + COORD_W'(box_h) + COORD_W'(1);
        col_neg <= 1'b0;
        count   <= box_w;
      end else begin
        row     <= COORD_W'(box_y);
        count   <= box_h;
        if (facing_left) begin
          col     <= COORD_W'(box_x) - COORD_W'(1);
          col_neg <= (box_x == '0);
        end else begin
          col     <= COORD_W'(box_x) + COORD_W'(box_w) + COORD_W'(1);
          col_neg <= 1'b0;
        end
      end
    end else begin
      if (cmd.setup) begin
        // address of the first pixel; only used while it is inside the map
        addr <= MAP_AW'(prod + (2*COORD_W)'(col));
      end
      if (cmd.step) begin
        count   <= count - SIZE_W'(1);
        outside <= outside | !in_map;
        if (walk_cols) begin
          col  <= col + COORD_W'(1);
          addr <= addr + MAP_AW'(1);
        end else begin
          row  <= row + COORD_W'(1);
          addr <= addr + MAP_AW'(eff_w);
        end
      end
      hit <= hit | (rd_pend & rd_data[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      contact     <= hit;
      outside_map <= outside;
    end
  end

endmodule

### sv/collision_bitmap_probe_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collision_bitmap_probe_top
// One-bit-per-pixel solid map with ground and wall edge probes.
// ----------------------------------------------------------------------------
// A load transaction writes one map bit without stalling and gives no result.
// A probe transaction keeps in_stall high from the accepting edge on: a setup
// state forms the start address (one multiply), a scan state walks the N bits
// of the edge, N being box_w for a ground probe and box_h for a wall probe, at
// one map bit per cycle through the single read port of the map RAM, a drain
// state lets the last read land and a done state moves the result into the
// output register. An empty edge skips the walk and the drain state.
// out_valid rises as the stall ends and the next transaction can be taken at
// that edge; a result still stalled at the output holds the following probe
// in its last cycle until it is taken. The map is not cleared at reset; probe
// only pixels that were loaded. Pixels outside the configured map read as
// empty and set outside_map.
// ----------------------------------------------------------------------------
module collision_bitmap_probe_top
  import cbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      command,
  input  logic [INDEX_W-1:0]    pixel_index,
  input  logic [PIXEL_W-1:0]    pixel_value,
  input  logic [POS_W-1:0]      box_x,
  input  logic [POS_W-1:0]      box_y,
  input  logic [SIZE_W-1:0]     box_w,
  input  logic [SIZE_W-1:0]     box_h,
  input  logic                  facing_left,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  contact,
  output logic                  outside_map
);

  cbp_cmd_t    cmd;
  cbp_status_t status;

  assign cfg_ready = 1'b1;

  cbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  cbp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .command     (command),
    .pixel_index (pixel_index),
    .pixel_value (pixel_value),
    .box_x       (box_x),
    .box_y       (box_y),
    .box_w       (box_w),
    .box_h       (box_h),
    .facing_left (facing_left),
    .contact     (contact),
    .outside_map (outside_map)
  );

endmodule

### sv/cbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_checker
// Port-level checks on the collision bitmap probe, bound to the top level.
// ----------------------------------------------------------------------------
module cbp_checker
  import cbp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [CMD_W-1:0]      command,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  contact,
  input logic                  outside_map
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(contact) && $stable(outside_map))
    else $error("stalled result changed");

  // a probe occupies the block for at least the next cycle
  a_probe_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == CMD_GROUND || command == CMD_WALL)
    |=> in_stall)
    else $error("probe did not occupy the block");

  // a load finishes in its own cycle
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_LOAD |=> !in_stall)
    else $error("load stalled the input");

  // a new result only follows a probe in progress
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a probe");

endmodule

bind collision_bitmap_probe_top cbp_checker u_cbp_checker (.*);

### sim/collision_bitmap_probe_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collision_bitmap_probe_top_tb
// Self-checking bench for the collision bitmap probe. The stimulus queue
// mixes pixel loads, ground probes and wall probes, and before every probe it
// loads each in-map pixel that the probe's edge will read and that has not
// been written yet. A shadow solid map predicts contact and outside_map for
// each accepted probe. Results are checked in order. The map setting is
// changed only between phases, while the block is idle. Outside the last,
// quiet phase both handshakes see random idle bursts.
// ----------------------------------------------------------------------------
module collision_bitmap_probe_top_tb;
  import cbp_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] index;
    logic [PIXEL_W-1:0] value;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic               left;
  } map_txn_t;

  typedef struct {
    logic contact;
    logic outside;
  } probe_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      command = '0;
  logic [INDEX_W-1:0]    pixel_index = '0;
  logic [PIXEL_W-1:0]    pixel_value = '0;
  logic [POS_W-1:0]      box_x = '0;
  logic [POS_W-1:0]      box_y = '0;
  logic [SIZE_W-1:0]     box_w = '0;
  logic [SIZE_W-1:0]     box_h = '0;
  logic                  facing_left = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  contact;
  logic                  outside_map;

  // shadow registers and map
  logic [DIMREG_W-1:0] width_reg  = 10'd512;
  logic [DIMREG_W-1:0] height_reg = 10'd512;
  logic [PIXEL_W-1:0]  key_reg    = '0;
  bit                  solid_bits [MAP_BITS];
  bit                  written_bits [MAP_BITS];

  map_txn_t      txn_queue[$];
  probe_result_t expected_hits[$];
  map_txn_t      cur_txn;

  int queued_count   = 0;
  int accepted_count = 0;
  int fail_count     = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int cycle_count    = 0;
  bit quiet          = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  collision_bitmap_probe_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .pixel_index (pixel_index),
    .pixel_value (pixel_value),
    .box_x       (box_x),
    .box_y       (box_y),
    .box_w       (box_w),
    .box_h       (box_h),
    .facing_left (facing_left),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .contact     (contact),
    .outside_map (outside_map)
  );

  function automatic int eff_dim(input logic [DIMREG_W-1:0] v, input int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  // In-map addresses along the probed edge; off is set if any pixel lies outside.
  function automatic void edge_pixels(input map_txn_t t, output int addrs[$],
                                      output logic off);
    int ew;
    int eh;
    int col;
    int row;
    int n;
    ew = eff_dim(width_reg, MAX_WIDTH);
    eh = eff_dim(height_reg, MAX_HEIGHT);
    addrs = {};
    off = 1'b0;
    n = (t.cmd == CMD_GROUND) ? int'(t.w) : int'(t.h);
    for (int i = 0; i < n; i++) begin
      if (t.cmd == CMD_GROUND) begin
        col = int'(t.x) + i;
        row = int'(t.y) + int'(t.h) + 1;
      end else begin
        col = t.left ? int'(t.x) - 1 : int'(t.x) + int'(t.w) + 1;
        row = int'(t.y) + i;
      end
      if (col < 0 || row < 0 || col >= ew || row >= eh) begin
        off = 1'b1;
      end else begin
        addrs.push_back(row * ew + col);
      end
    end
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_color();
    return ($urandom_range(0, 2) == 0) ? key_reg : PIXEL_W'($urandom());
  endfunction

  // dimension value with random junk above the register width now and then
  function automatic logic [CFG_DATA_W-1:0] dim_word(input int v);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom_range(0, 1) ? (CFG_DATA_W'($urandom()) & ~32'h3FF) : '0;
    return junk | CFG_DATA_W'(v & 32'h3FF);
  endfunction

  task automatic push_txn(input map_txn_t t);
    txn_queue.push_back(t);
    queued_count++;
  endtask

  task automatic push_load(input int index, input logic [PIXEL_W-1:0] value);
    map_txn_t t;
    t = '{cmd: CMD_LOAD, index: INDEX_W'(index), value: value,
          x: POS_W'($urandom()), y: POS_W'($urandom()), w: SIZE_W'($urandom()),
          h: SIZE_W'($urandom()), left: 1'($urandom())};
    written_bits[index] = 1'b1;
    push_txn(t);
  endtask

  // Loads every unwritten pixel the probe will read, then queues the probe.
  task automatic add_probe(input logic [CMD_W-1:0] cmd, input int x, y, w, h,
                           input logic left);
    map_txn_t t;
    int       addrs[$];
    logic     off;
    t = '{cmd: cmd, index: INDEX_W'($urandom()), value: PIXEL_W'($urandom()),
          x: POS_W'(x), y: POS_W'(y), w: SIZE_W'(w), h: SIZE_W'(h), left: left};
    edge_pixels(t, addrs, off);
    foreach (addrs[i]) begin
      if (!written_bits[addrs[i]]) begin
        push_load(addrs[i], pick_color());
      end
    end
    push_txn(t);
  endtask

  // Caller is aligned to a rising edge; cfg_valid stays high across writes.
  task automatic write_reg(input cbp_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAP_WIDTH: begin
        width_reg = data[DIMREG_W-1:0];
      end
      REG_MAP_HEIGHT: begin
        height_reg = data[DIMREG_W-1:0];
      end
      default: begin
        key_reg = data;
      end
    endcase
  endtask

  task automatic set_map(input int w, input int h, input logic [PIXEL_W-1:0] key);
    write_reg(REG_MAP_WIDTH, dim_word(w));
    write_reg(REG_MAP_HEIGHT, dim_word(h));
    write_reg(REG_COLOR_KEY, key);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (accepted_count != queued_count || expected_hits.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_items(input int count);
    int               start;
    int               sel;
    int               ew;
    int               eh;
    int               scan;
    int               other;
    int               x;
    int               y;
    logic [CMD_W-1:0] cmd;
    map_txn_t         t;
    start = queued_count;
    ew = eff_dim(width_reg, MAX_WIDTH);
    eh = eff_dim(height_reg, MAX_HEIGHT);
    while (queued_count - start < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        t = '{cmd: CMD_UNUSED, index: INDEX_W'($urandom()), value: PIXEL_W'($urandom()),
              x: POS_W'($urandom()), y: POS_W'($urandom()), w: SIZE_W'($urandom()),
              h: SIZE_W'($urandom()), left: 1'($urandom())};
        push_txn(t);
      end else if (sel < 22) begin
        if (sel < 13 && ew * eh > 0) begin
          push_load($urandom_range(0, ew * eh - 1), pick_color());
        end else begin
          push_load($urandom_range(0, MAP_BITS - 1), pick_color());
        end
      end else begin
        cmd  = $urandom_range(0, 1) ? CMD_GROUND : CMD_WALL;
        // long edges are rare and kept to small maps, where few fill loads are needed
        scan = ($urandom_range(0, 49) == 0 && ew * eh <= 4096) ?
               $urandom_range(0, 512) : $urandom_range(0, 24);
        if ($urandom_range(0, 3) == 0) begin
          x     = $urandom_range(0, 511);
          y     = $urandom_range(0, 511);
          other = $urandom_range(0, 512);
        end else begin
          x     = $urandom_range(0, (ew < 511) ? ew + 1 : 511);
          y     = $urandom_range(0, (eh < 511) ? eh + 1 : 511);
          other = $urandom_range(0, 3);
        end
        if (cmd == CMD_GROUND) begin
          add_probe(cmd, x, y, scan, other, 1'($urandom()));
        end else begin
          add_probe(cmd, x, y, other, scan, 1'($urandom()));
        end
      end
    end
  endtask

  // input driver; the shadow model is updated at each accepted transaction
  always @(posedge clk) begin : drive_inputs
    int   addrs[$];
    logic off;
    logic hit;
    logic next_valid;
    next_valid = in_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur_txn.cmd == CMD_LOAD) begin
          solid_bits[cur_txn.index] = (cur_txn.value != key_reg);
        end else if (cur_txn.cmd == CMD_GROUND || cur_txn.cmd == CMD_WALL) begin
          edge_pixels(cur_txn, addrs, off);
          hit = 1'b0;
          foreach (addrs[i]) begin
            hit |= solid_bits[addrs[i]];
          end
          expected_hits.push_back('{contact: hit, outside: off});
        end
        accepted_count++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (txn_queue.size() != 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 7);
          end else begin
            cur_txn     = txn_queue.pop_front();
            command     <= cur_txn.cmd;
            pixel_index <= cur_txn.index;
            pixel_value <= cur_txn.value;
            box_x       <= cur_txn.x;
            box_y       <= cur_txn.y;
            box_w       <= cur_txn.w;
            box_h       <= cur_txn.h;
            facing_left <= cur_txn.left;
            next_valid  = 1'b1;
          end
        end
      end
    end
    in_valid <= next_valid;
  end

  always @(posedge clk) begin : stall_outputs
    if (rst || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    probe_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected result: contact %0b outside_map %0b", contact, outside_map);
        end
      end else begin
        want = expected_hits.pop_front();
        if (contact !== want.contact || outside_map !== want.outside) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("result mismatch: contact exp %0b got %0b, outside_map exp %0b got %0b",
                     want.contact, contact, want.outside, outside_map);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : run_test
    map_txn_t t;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset setting: 512 x 512, key 0
    push_load(0, 32'h0000_0000);
    push_load(MAP_BITS - 1, 32'hFFFF_FFFF);
    t = '{cmd: CMD_UNUSED, index: '1, value: '1, x: '1, y: '1, w: 10'd512, h: 10'd512,
          left: 1'b1};
    push_txn(t);
    add_probe(CMD_GROUND, 0, 0, 0, 0, 1'b0);       // empty ground edge
    add_probe(CMD_WALL, 5, 5, 3, 0, 1'b0);         // empty wall edge
    add_probe(CMD_WALL, 0, 0, 0, 3, 1'b1);         // column -1
    add_probe(CMD_GROUND, 511, 509, 1, 1, 1'b0);   // last pixel of the map
    add_probe(CMD_GROUND, 510, 509, 3, 1, 1'b0);   // runs past the right side
    add_probe(CMD_WALL, 509, 510, 1, 3, 1'b0);     // runs past the bottom
    add_probe(CMD_WALL, 1, 0, 0, 2, 1'b1);         // column 0 from the left
    add_probe(CMD_GROUND, 511, 511, 5, 512, 1'b0); // row far below the map
    drain();

    // small map, key all ones: longest edges stay cheap here
    set_map(16, 12, 32'hFFFF_FFFF);
    push_load(5, 32'hFFFF_FFFF);
    push_load(6, 32'h0000_0000);
    add_probe(CMD_GROUND, 0, 0, 512, 0, 1'b0);
    add_probe(CMD_WALL, 511, 0, 512, 512, 1'b0);
    add_probe(CMD_WALL, 8, 0, 0, 512, 1'b1);
    add_probe(CMD_WALL, 0, 2, 512, 5, 1'b1);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_map(512, 512, $urandom());
        1: set_map(1023, 1023, 32'h0000_0000);
        2: set_map(0, 300, $urandom());
        3: set_map(300, 0, $urandom());
        4: set_map(1, 1, 32'hFFFF_FFFF);
        5: set_map(23, 17, $urandom());
        6: set_map(512, 1, $urandom());
        7: set_map(1, 512, $urandom());
        default: set_map($urandom_range(1, 64), $urandom_range(1, 64), $urandom());
      endcase
      if (p == 9) begin
        quiet = 1'b1;
      end
      random_items(62);
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
